// ===== rtl/mbqsp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the modified biquad shelf/peak filter.
package mbqsp_pkg;

    localparam int REG_BITS      = 24;
    localparam int COMB_BITS     = 28;
    localparam int DIGIT_BITS    = 4;
    localparam int APB_ADDR_BITS = 5;
    localparam int APB_DATA_BITS = 32;

    typedef enum logic [2:0] {
        REG_A0  = 3'd0,
        REG_A1  = 3'd1,
        REG_A2  = 3'd2,
        REG_B1  = 3'd3,
        REG_B2  = 3'd4,
        REG_WET = 3'd5,
        REG_DRY = 3'd6
    } reg_idx_t;

    typedef logic signed [REG_BITS-1:0] coeff_word_t;

    typedef struct packed {
        coeff_word_t a0;
        coeff_word_t a1;
        coeff_word_t a2;
        coeff_word_t b1;
        coeff_word_t b2;
        coeff_word_t wet;
        coeff_word_t dry;
    } coeff_set_t;

    typedef struct packed {
        logic start;
        logic clear;
        logic negate;
    } mac_cmd_t;

endpackage

// ===== rtl/mbqsp_ifs.sv =====
`timescale 1ns / 1ps
// Sample stream interfaces for the filter input and output channels.
interface mbqsp_in_if #(parameter int SAMPLE_BITS = 24);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface mbqsp_out_if #(parameter int SAMPLE_BITS = 24);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] filt_out;

    modport source (output valid, output filt_out, input ready);
    modport sink   (input valid, input filt_out, output ready);
endinterface

// ===== rtl/modified_biquad_shelf_peak_filter.sv =====
`timescale 1ns / 1ps
// Top level of the modified biquad shelf/peak filter.
//
// Second-order IIR equalizer section. Every sample word taken on in_ch yields
// exactly one saturated sample word on out_ch. All ten products (three wet
// terms, two dry terms, five dot-product terms) go through one shared
// digit-serial multiply-accumulate unit that retires four multiplier bits a
// cycle. The block takes one sample at a time; the next sample is accepted
// as soon as the previous result sits in the output register, even while
// that result still waits for out_ch.ready. Coefficients are written over
// APB (registers at byte addresses 0x00..0x18, index 7 is ignored) and must
// only be changed while no sample is in flight.
module modified_biquad_shelf_peak_filter #(
    parameter int SAMPLE_BITS     = 24,
    parameter int COEFF_FRAC_BITS = 20
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    mbqsp_in_if.sink                             in_ch,
    mbqsp_out_if.source                          out_ch,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [mbqsp_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [mbqsp_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [mbqsp_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                 pready
);

    localparam int RB    = mbqsp_pkg::REG_BITS;
    localparam int CB    = mbqsp_pkg::COMB_BITS;
    localparam int F     = COEFF_FRAC_BITS;
    localparam int MQ_W  = (SAMPLE_BITS > RB) ? SAMPLE_BITS : RB;
    localparam int CMB_W = ((2 * RB > RB + F) ? 2 * RB : RB + F) + 2;
    localparam int DOT_W = CB + SAMPLE_BITS + 3;
    localparam int ACC_W = (CMB_W > DOT_W) ? CMB_W : DOT_W;

    localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(64'sd1 <<< (F - 1));
    localparam logic signed [ACC_W-1:0] COMB_MAX = ACC_W'((64'sd1 <<< (CB - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] COMB_MIN = ACC_W'(-(64'sd1 <<< (CB - 1)));
    localparam logic signed [ACC_W-1:0] SMP_MAX  =
        ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SMP_MIN  = ACC_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

    // Sequencer: combine the coefficients, then run the five-tap dot product.
    typedef enum logic [14:0] {
        ST_IDLE = 15'b000000000000001,
        ST_K0M  = 15'b000000000000010,
        ST_K0R  = 15'b000000000000100,
        ST_K1D  = 15'b000000000001000,
        ST_K1W  = 15'b000000000010000,
        ST_K1R  = 15'b000000000100000,
        ST_K2D  = 15'b000000001000000,
        ST_K2W  = 15'b000000010000000,
        ST_K2R  = 15'b000000100000000,
        ST_X0   = 15'b000001000000000,
        ST_X1   = 15'b000010000000000,
        ST_X2   = 15'b000100000000000,
        ST_Y1   = 15'b001000000000000,
        ST_Y2   = 15'b010000000000000,
        ST_OUT  = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   go_reg, go_next;

    logic signed [SAMPLE_BITS-1:0] x0_reg, x0_next;
    logic signed [SAMPLE_BITS-1:0] x1_reg, x1_next;
    logic signed [SAMPLE_BITS-1:0] x2_reg, x2_next;
    logic signed [SAMPLE_BITS-1:0] y1_reg, y1_next;
    logic signed [SAMPLE_BITS-1:0] y2_reg, y2_next;
    logic signed [CB-1:0]          k0_reg, k0_next;
    logic signed [CB-1:0]          k1_reg, k1_next;
    logic signed [CB-1:0]          k2_reg, k2_next;
    logic                          out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] out_data_reg, out_data_next;

    mbqsp_pkg::coeff_set_t   coeffs;
    mbqsp_pkg::mac_cmd_t     mac_cmd;
    logic signed [ACC_W-1:0] mac_mcand;
    logic signed [MQ_W-1:0]  mac_mplier;
    logic signed [ACC_W-1:0] mac_init;
    logic signed [ACC_W-1:0] mac_acc;
    logic                    mac_done;

    logic signed [ACC_W-1:0]       rnd_sum;
    logic signed [ACC_W-1:0]       rnd_val;
    logic signed [CB-1:0]          k_sat;
    logic signed [SAMPLE_BITS-1:0] y_sat;
    logic                          in_acc;

    mbqsp_regs #(
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coeffs  (coeffs)
    );

    mbqsp_mac #(
        .ACC_W (ACC_W),
        .MQ_W  (MQ_W)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (mac_cmd),
        .mcand  (mac_mcand),
        .mplier (mac_mplier),
        .init   (mac_init),
        .acc    (mac_acc),
        .done   (mac_done)
    );

    assign in_ch.ready     = (state_reg == ST_IDLE);
    assign in_acc          = in_ch.valid && in_ch.ready;
    assign out_ch.valid    = out_valid_reg;
    assign out_ch.filt_out = out_data_reg;

    // Round half up at the binary point, then clamp for both result widths.
    always_comb
    begin
        rnd_sum = mac_acc + RND_BIAS;
        rnd_val = rnd_sum >>> F;

        if (rnd_val > COMB_MAX)
            k_sat = CB'(COMB_MAX);
        else if (rnd_val < COMB_MIN)
            k_sat = CB'(COMB_MIN);
        else
            k_sat = CB'(rnd_val);

        if (rnd_val > SMP_MAX)
            y_sat = SAMPLE_BITS'(SMP_MAX);
        else if (rnd_val < SMP_MIN)
            y_sat = SAMPLE_BITS'(SMP_MIN);
        else
            y_sat = SAMPLE_BITS'(rnd_val);
    end

    // Operand selection for the shared multiply-accumulate unit.
    always_comb
    begin
        mac_cmd.start  = go_reg;
        mac_cmd.clear  = 1'b0;
        mac_cmd.negate = 1'b0;
        mac_mcand      = '0;
        mac_mplier     = '0;
        mac_init       = '0;
        case (state_reg)
            ST_K0M:
            begin
                // seed with the dry path, dry_gain times one
                mac_cmd.clear = 1'b1;
                mac_init      = ACC_W'($signed(coeffs.dry)) <<< F;
                mac_mcand     = ACC_W'($signed(coeffs.wet));
                mac_mplier    = MQ_W'($signed(coeffs.a0));
            end
            ST_K1D:
            begin
                mac_cmd.clear = 1'b1;
                mac_mcand     = ACC_W'($signed(coeffs.dry));
                mac_mplier    = MQ_W'($signed(coeffs.b1));
            end
            ST_K1W:
            begin
                mac_mcand  = ACC_W'($signed(coeffs.wet));
                mac_mplier = MQ_W'($signed(coeffs.a1));
            end
            ST_K2D:
            begin
                mac_cmd.clear = 1'b1;
                mac_mcand     = ACC_W'($signed(coeffs.dry));
                mac_mplier    = MQ_W'($signed(coeffs.b2));
            end
            ST_K2W:
            begin
                mac_mcand  = ACC_W'($signed(coeffs.wet));
                mac_mplier = MQ_W'($signed(coeffs.a2));
            end
            ST_X0:
            begin
                mac_cmd.clear = 1'b1;
                mac_mcand     = ACC_W'(k0_reg);
                mac_mplier    = MQ_W'(x0_reg);
            end
            ST_X1:
            begin
                mac_mcand  = ACC_W'(k1_reg);
                mac_mplier = MQ_W'(x1_reg);
            end
            ST_X2:
            begin
                mac_mcand  = ACC_W'(k2_reg);
                mac_mplier = MQ_W'(x2_reg);
            end
            ST_Y1:
            begin
                mac_cmd.negate = 1'b1;
                mac_mcand      = ACC_W'($signed(coeffs.b1));
                mac_mplier     = MQ_W'(y1_reg);
            end
            ST_Y2:
            begin
                mac_cmd.negate = 1'b1;
                mac_mcand      = ACC_W'($signed(coeffs.b2));
                mac_mplier     = MQ_W'(y2_reg);
            end
            default: ;
        endcase
    end

    // Sequencer and history update.
    always_comb
    begin
        state_next     = state_reg;
        go_next        = 1'b0;
        x0_next        = x0_reg;
        x1_next        = x1_reg;
        x2_next        = x2_reg;
        y1_next        = y1_reg;
        y2_next        = y2_reg;
        k0_next        = k0_reg;
        k1_next        = k1_reg;
        k2_next        = k2_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        // drop the output word once it is taken
        if (out_valid_reg && out_ch.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    x0_next    = in_ch.sample_in;
                    state_next = ST_K0M;
                    go_next    = 1'b1;
                end
            end
            ST_K0M:
            begin
                if (mac_done)
                    state_next = ST_K0R;
            end
            ST_K0R:
            begin
                k0_next    = k_sat;
                state_next = ST_K1D;
                go_next    = 1'b1;
            end
            ST_K1D:
            begin
                if (mac_done)
                begin
                    state_next = ST_K1W;
                    go_next    = 1'b1;
                end
            end
            ST_K1W:
            begin
                if (mac_done)
                    state_next = ST_K1R;
            end
            ST_K1R:
            begin
                k1_next    = k_sat;
                state_next = ST_K2D;
                go_next    = 1'b1;
            end
            ST_K2D:
            begin
                if (mac_done)
                begin
                    state_next = ST_K2W;
                    go_next    = 1'b1;
                end
            end
            ST_K2W:
            begin
                if (mac_done)
                    state_next = ST_K2R;
            end
            ST_K2R:
            begin
                k2_next    = k_sat;
                state_next = ST_X0;
                go_next    = 1'b1;
            end
            ST_X0:
            begin
                if (mac_done)
                begin
                    state_next = ST_X1;
                    go_next    = 1'b1;
                end
            end
            ST_X1:
            begin
                if (mac_done)
                begin
                    state_next = ST_X2;
                    go_next    = 1'b1;
                end
            end
            ST_X2:
            begin
                if (mac_done)
                begin
                    state_next = ST_Y1;
                    go_next    = 1'b1;
                end
            end
            ST_Y1:
            begin
                if (mac_done)
                begin
                    state_next = ST_Y2;
                    go_next    = 1'b1;
                end
            end
            ST_Y2:
            begin
                if (mac_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // hold the result until the output register is free
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_data_next  = y_sat;
                    out_valid_next = 1'b1;
                    x2_next        = x1_reg;
                    x1_next        = x0_reg;
                    y2_next        = y1_reg;
                    y1_next        = y_sat;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            go_reg        <= 1'b0;
            x1_reg        <= '0;
            x2_reg        <= '0;
            y1_reg        <= '0;
            y2_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            go_reg        <= go_next;
            x1_reg        <= x1_next;
            x2_reg        <= x2_next;
            y1_reg        <= y1_next;
            y2_reg        <= y2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x0_reg       <= x0_next;
        k0_reg       <= k0_next;
        k1_reg       <= k1_next;
        k2_reg       <= k2_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ===== rtl/mbqsp_regs.sv =====
`timescale 1ns / 1ps
// APB coefficient register file of the filter.
module mbqsp_regs #(
    parameter int COEFF_FRAC_BITS = 20
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [mbqsp_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [mbqsp_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [mbqsp_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                  pready,
    output mbqsp_pkg::coeff_set_t                 coeffs
);

    localparam logic [mbqsp_pkg::REG_BITS-1:0] WET_RESET =
        mbqsp_pkg::REG_BITS'(64'd1 << COEFF_FRAC_BITS);

    mbqsp_pkg::coeff_set_t coeffs_reg;
    mbqsp_pkg::reg_idx_t   idx;
    logic                  wr_en;
    mbqsp_pkg::coeff_word_t rd_word;

    assign idx    = mbqsp_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign coeffs = coeffs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeffs_reg.a0  <= '0;
            coeffs_reg.a1  <= '0;
            coeffs_reg.a2  <= '0;
            coeffs_reg.b1  <= '0;
            coeffs_reg.b2  <= '0;
            coeffs_reg.wet <= WET_RESET;
            coeffs_reg.dry <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                mbqsp_pkg::REG_A0:  coeffs_reg.a0  <= pwdata[mbqsp_pkg::REG_BITS-1:0];
                mbqsp_pkg::REG_A1:  coeffs_reg.a1  <= pwdata[mbqsp_pkg::REG_BITS-1:0];
                mbqsp_pkg::REG_A2:  coeffs_reg.a2  <= pwdata[mbqsp_pkg::REG_BITS-1:0];
                mbqsp_pkg::REG_B1:  coeffs_reg.b1  <= pwdata[mbqsp_pkg::REG_BITS-1:0];
                mbqsp_pkg::REG_B2:  coeffs_reg.b2  <= pwdata[mbqsp_pkg::REG_BITS-1:0];
                mbqsp_pkg::REG_WET: coeffs_reg.wet <= pwdata[mbqsp_pkg::REG_BITS-1:0];
                mbqsp_pkg::REG_DRY: coeffs_reg.dry <= pwdata[mbqsp_pkg::REG_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            mbqsp_pkg::REG_A0:  rd_word = coeffs_reg.a0;
            mbqsp_pkg::REG_A1:  rd_word = coeffs_reg.a1;
            mbqsp_pkg::REG_A2:  rd_word = coeffs_reg.a2;
            mbqsp_pkg::REG_B1:  rd_word = coeffs_reg.b1;
            mbqsp_pkg::REG_B2:  rd_word = coeffs_reg.b2;
            mbqsp_pkg::REG_WET: rd_word = coeffs_reg.wet;
            mbqsp_pkg::REG_DRY: rd_word = coeffs_reg.dry;
            default:            rd_word = '0;
        endcase
        prdata = {{(mbqsp_pkg::APB_DATA_BITS-mbqsp_pkg::REG_BITS){1'b0}}, rd_word};
    end

endmodule

// ===== rtl/mbqsp_mac.sv =====
`timescale 1ns / 1ps
// Digit-serial signed multiply-accumulate unit, one multiplier digit per cycle.
module mbqsp_mac #(
    parameter int ACC_W = 63,
    parameter int MQ_W  = 24
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mbqsp_pkg::mac_cmd_t      cmd,
    input  logic signed [ACC_W-1:0]  mcand,
    input  logic signed [MQ_W-1:0]   mplier,
    input  logic signed [ACC_W-1:0]  init,
    output logic signed [ACC_W-1:0]  acc,
    output logic                     done
);

    localparam int DB    = mbqsp_pkg::DIGIT_BITS;
    localparam int NDIG  = (MQ_W + DB - 1) / DB;
    localparam int Q_W   = NDIG * DB;
    localparam int CNT_W = (NDIG > 1) ? $clog2(NDIG) : 1;

    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0] m_reg, m_next;
    logic signed [Q_W-1:0]   q_reg, q_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic                    neg_reg, neg_next;
    logic                    last;
    logic [DB-1:0]           digit;
    logic signed [DB:0]      dig_s;
    logic signed [ACC_W-1:0] prod;

    assign acc  = acc_reg;
    assign done = done_reg;

    always_comb
    begin
        last  = (cnt_reg == CNT_W'(NDIG - 1));
        digit = q_reg[DB-1:0];
        // top digit carries the sign weight
        if (last)
            dig_s = signed'({digit[DB-1], digit});
        else
            dig_s = signed'({1'b0, digit});
        prod = m_reg * dig_s;

        acc_next  = acc_reg;
        m_next    = m_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;

        if (busy_reg)
        begin
            acc_next = neg_reg ? (acc_reg - prod) : (acc_reg + prod);
            m_next   = m_reg <<< DB;
            q_next   = q_reg >>> DB;
            cnt_next = cnt_reg + CNT_W'(1);
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end

        if (cmd.start)
        begin
            m_next    = mcand;
            q_next    = Q_W'(mplier);
            cnt_next  = '0;
            busy_next = 1'b1;
            neg_next  = cmd.negate;
            if (cmd.clear)
                acc_next = init;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            neg_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            neg_reg  <= neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        m_reg   <= m_next;
        q_reg   <= q_next;
    end

endmodule

// ===== rtl/mbqsp_checker.sv =====
`timescale 1ns / 1ps
// Port-level assertions for the filter top level, with the bind that attaches them.
module mbqsp_checker #(
    parameter int SAMPLE_BITS = 24
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [SAMPLE_BITS-1:0] filt_out
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(filt_out))
        else $error("stalled output word changed");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again right after an accept");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared one cycle after accept");

    a_busy_only_by_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid && in_ready))
        else $error("input side went busy without an accepted word");

endmodule

bind modified_biquad_shelf_peak_filter mbqsp_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .filt_out  (out_ch.filt_out)
);
